// File: hw/rtl/afap_pkg.sv
`timescale 1ns / 1ps
// Package for the arm / fire / abort panel sequencer.
// Types, action codes, register indexes and fixed tone constants; no dependencies.
package afap_pkg;

  localparam int TIME_W    = 32;
  localparam int MAX_RES   = 8;
  localparam int RES_IDX_W = $clog2(MAX_RES);
  localparam int RES_CNT_W = $clog2(MAX_RES + 1);
  localparam int CFG_IDX_W = 8;
  localparam int CFG_DAT_W = 32;

  // result actions
  localparam logic [2:0] ACT_ARM     = 3'd0;
  localparam logic [2:0] ACT_STOP    = 3'd1;
  localparam logic [2:0] ACT_FIRE    = 3'd2;
  localparam logic [2:0] ACT_ABORT   = 3'd3;
  localparam logic [2:0] ACT_BEEP    = 3'd4;
  localparam logic [2:0] ACT_SILENCE = 3'd5;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ABORT_REPEAT  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_AUTO_DISARM   = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BEEP_INTERVAL = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BEEP_LENGTH   = 8'd3;

  // register reset values
  localparam logic [15:0] ABORT_REPEAT_RST  = 16'd500;
  localparam logic [19:0] AUTO_DISARM_RST   = 20'd30000;
  localparam logic [15:0] BEEP_INTERVAL_RST = 16'd1000;
  localparam logic [15:0] BEEP_LENGTH_RST   = 16'd100;

  // fixed tones
  localparam logic [10:0] ARM_TONE_HZ  = 11'd1000;
  localparam logic [15:0] ARM_TONE_MS  = 16'd100;
  localparam logic [10:0] FIRE_TONE_HZ = 11'd2000;
  localparam logic [15:0] FIRE_TONE_MS = 16'd30;
  localparam logic [10:0] REM_TONE_HZ  = 11'd1000;
  localparam int          FIRE_BEEPS   = 3;

  typedef struct packed {
    logic [2:0]  action;
    logic [10:0] tone_hz;
    logic [15:0] tone_ms;
  } afap_res_t;

endpackage

// File: hw/rtl/afap_in_if.sv
`timescale 1ns / 1ps
// Sample channel of the panel sequencer: valid/ready plus switch levels and timestamp.
// Depends on afap_pkg.
interface afap_in_if;
  import afap_pkg::*;

  logic              valid;
  logic              ready;
  logic              arm_level;
  logic              fire_level;
  logic              abort_level;
  logic [TIME_W-1:0] now_ms;

  modport source (output valid, arm_level, fire_level, abort_level, now_ms, input ready);
  modport sink   (input valid, arm_level, fire_level, abort_level, now_ms, output ready);
endinterface

// File: hw/rtl/afap_out_if.sv
`timescale 1ns / 1ps
// Result channel of the panel sequencer: valid/ready plus action, tone and last flag.
// Depends on afap_pkg.
interface afap_out_if;
  import afap_pkg::*;

  logic        valid;
  logic        ready;
  logic [2:0]  action;
  logic [10:0] tone_hz;
  logic [15:0] tone_ms;
  logic        last;

  modport source (output valid, action, tone_hz, tone_ms, last, input ready);
  modport sink   (input valid, action, tone_hz, tone_ms, last, output ready);
endinterface

// File: hw/rtl/afap_cfg_if.sv
`timescale 1ns / 1ps
// Configuration write channel: valid/ready plus register index and write data.
// Depends on afap_pkg.
interface afap_cfg_if;
  import afap_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_DAT_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: hw/rtl/arm_fire_abort_panel_sequencer.sv
`timescale 1ns / 1ps
// Arm / fire / abort panel sequencer. A sample is taken into an input register, then its
// edges are decoded combinationally, state updated and its 0..8 results written to a result list.
// The result list loads from the input register once the list is empty or its last entry is
// taken, and the result channel then offers the first result from the registered list.
// The input register can take a new sample while the previous list drains; the single result
// channel drains the list one entry per cycle while ready is high, at most 8 entries per sample.
// Reset (synchronous, rst_n low): registers to defaults, panel disarmed with abort released, lists empty.
module arm_fire_abort_panel_sequencer (
  input  logic            clk,
  input  logic            rst_n,
  afap_in_if.sink         in_ch,
  afap_out_if.source      out_ch,
  afap_cfg_if.sink        cfg_ch
);
  import afap_pkg::*;

  // configuration
  logic [15:0] abort_repeat_r;
  logic [19:0] auto_disarm_r;
  logic [15:0] beep_interval_r;
  logic [15:0] beep_length_r;

  // panel state
  logic              arm_prev_r, fire_prev_r, abort_prev_r, is_armed_r;
  logic [TIME_W-1:0] armed_since_r, last_beep_r, last_abort_r;
  logic              is_armed_nxt;
  logic [TIME_W-1:0] armed_since_nxt, last_beep_nxt, last_abort_nxt;

  // input register
  logic              in_vld_r;
  logic              in_arm_r, in_fire_r, in_abort_r;
  logic [TIME_W-1:0] in_now_r;

  // result list
  afap_res_t            list_r   [MAX_RES];
  afap_res_t            list_nxt [MAX_RES];
  logic [RES_CNT_W-1:0] out_cnt_r;
  logic [RES_CNT_W-1:0] cnt_nxt;
  logic [RES_IDX_W-1:0] out_idx_r;

  logic              take, take_last, load, in_take, is_last;
  logic              arm_rise, arm_fall, fire_rise;
  logic [TIME_W-1:0] el_abort, el_armed, el_beep;
  afap_res_t         cur;

  assign cfg_ch.ready = 1'b1;

  assign is_last   = ({1'b0, out_idx_r} + RES_CNT_W'(1)) == out_cnt_r;
  assign take      = out_ch.valid && out_ch.ready;
  assign take_last = take && is_last;
  assign load      = in_vld_r && ((out_cnt_r == '0) || take_last);
  assign in_ch.ready = !in_vld_r || load;
  assign in_take   = in_ch.valid && in_ch.ready;

  assign cur           = list_r[out_idx_r];
  assign out_ch.valid  = out_cnt_r != '0;
  assign out_ch.action = cur.action;
  assign out_ch.tone_hz = cur.tone_hz;
  assign out_ch.tone_ms = cur.tone_ms;
  assign out_ch.last   = is_last;

  assign arm_rise  = in_arm_r && !arm_prev_r && in_abort_r;
  assign arm_fall  = !in_arm_r && arm_prev_r;
  assign fire_rise = in_fire_r && !fire_prev_r;

  // decode one sample into its result list and next state
  always_comb begin
    for (int k = 0; k < MAX_RES; k++) begin
      list_nxt[k] = '0;
    end
    cnt_nxt         = '0;
    is_armed_nxt    = is_armed_r;
    armed_since_nxt = armed_since_r;
    last_beep_nxt   = last_beep_r;
    last_abort_nxt  = last_abort_r;

    if (arm_rise) begin
      list_nxt[cnt_nxt[RES_IDX_W-1:0]] = '{ACT_ARM, 11'd0, 16'd0};
      cnt_nxt = cnt_nxt + RES_CNT_W'(1);
      list_nxt[cnt_nxt[RES_IDX_W-1:0]] = '{ACT_BEEP, ARM_TONE_HZ, ARM_TONE_MS};
      cnt_nxt = cnt_nxt + RES_CNT_W'(1);
      is_armed_nxt    = 1'b1;
      armed_since_nxt = in_now_r;
      last_beep_nxt   = in_now_r;
    end else if (arm_fall) begin
      list_nxt[cnt_nxt[RES_IDX_W-1:0]] = '{ACT_STOP, 11'd0, 16'd0};
      cnt_nxt = cnt_nxt + RES_CNT_W'(1);
      list_nxt[cnt_nxt[RES_IDX_W-1:0]] = '{ACT_SILENCE, 11'd0, 16'd0};
      cnt_nxt = cnt_nxt + RES_CNT_W'(1);
      is_armed_nxt = 1'b0;
    end

    if (fire_rise && is_armed_nxt) begin
      list_nxt[cnt_nxt[RES_IDX_W-1:0]] = '{ACT_FIRE, 11'd0, 16'd0};
      cnt_nxt = cnt_nxt + RES_CNT_W'(1);
      for (int b = 0; b < FIRE_BEEPS; b++) begin
        list_nxt[cnt_nxt[RES_IDX_W-1:0]] = '{ACT_BEEP, FIRE_TONE_HZ, FIRE_TONE_MS};
        cnt_nxt = cnt_nxt + RES_CNT_W'(1);
      end
    end

    el_abort = in_now_r - last_abort_r;
    if (!in_abort_r) begin
      if (el_abort >= TIME_W'(abort_repeat_r)) begin
        list_nxt[cnt_nxt[RES_IDX_W-1:0]] = '{ACT_ABORT, 11'd0, 16'd0};
        cnt_nxt = cnt_nxt + RES_CNT_W'(1);
        last_abort_nxt = in_now_r;
      end
    end else if (!abort_prev_r) begin
      list_nxt[cnt_nxt[RES_IDX_W-1:0]] = '{ACT_STOP, 11'd0, 16'd0};
      cnt_nxt = cnt_nxt + RES_CNT_W'(1);
    end

    // arming in this sample restarts both timers at zero elapsed
    el_armed = in_now_r - armed_since_nxt;
    el_beep  = in_now_r - last_beep_nxt;
    if (is_armed_nxt) begin
      if (el_armed >= TIME_W'(auto_disarm_r)) begin
        list_nxt[cnt_nxt[RES_IDX_W-1:0]] = '{ACT_STOP, 11'd0, 16'd0};
        cnt_nxt = cnt_nxt + RES_CNT_W'(1);
        is_armed_nxt = 1'b0;
      end else if (el_beep >= TIME_W'(beep_interval_r)) begin
        list_nxt[cnt_nxt[RES_IDX_W-1:0]] = '{ACT_BEEP, REM_TONE_HZ, beep_length_r};
        cnt_nxt = cnt_nxt + RES_CNT_W'(1);
        last_beep_nxt = in_now_r;
      end
    end
  end

  // control and state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      abort_repeat_r  <= ABORT_REPEAT_RST;
      auto_disarm_r   <= AUTO_DISARM_RST;
      beep_interval_r <= BEEP_INTERVAL_RST;
      beep_length_r   <= BEEP_LENGTH_RST;
      arm_prev_r      <= 1'b0;
      fire_prev_r     <= 1'b0;
      abort_prev_r    <= 1'b1;
      is_armed_r      <= 1'b0;
      armed_since_r   <= '0;
      last_beep_r     <= '0;
      last_abort_r    <= '0;
      in_vld_r        <= 1'b0;
      out_cnt_r       <= '0;
      out_idx_r       <= '0;
    end else begin
      if (cfg_ch.valid) begin
        case (cfg_ch.index)
          REG_ABORT_REPEAT:  abort_repeat_r  <= cfg_ch.data[15:0];
          REG_AUTO_DISARM:   auto_disarm_r   <= cfg_ch.data[19:0];
          REG_BEEP_INTERVAL: beep_interval_r <= cfg_ch.data[15:0];
          REG_BEEP_LENGTH:   beep_length_r   <= cfg_ch.data[15:0];
          default: ;
        endcase
      end

      if (in_take) begin
        in_vld_r <= 1'b1;
      end else if (load) begin
        in_vld_r <= 1'b0;
      end

      if (load) begin
        arm_prev_r    <= in_arm_r;
        fire_prev_r   <= in_fire_r;
        abort_prev_r  <= in_abort_r;
        is_armed_r    <= is_armed_nxt;
        armed_since_r <= armed_since_nxt;
        last_beep_r   <= last_beep_nxt;
        last_abort_r  <= last_abort_nxt;
        out_cnt_r     <= cnt_nxt;
        out_idx_r     <= '0;
      end else if (take_last) begin
        out_cnt_r <= '0;
        out_idx_r <= '0;
      end else if (take) begin
        out_idx_r <= out_idx_r + RES_IDX_W'(1);
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (in_take) begin
      in_arm_r   <= in_ch.arm_level;
      in_fire_r  <= in_ch.fire_level;
      in_abort_r <= in_ch.abort_level;
      in_now_r   <= in_ch.now_ms;
    end
    if (load) begin
      for (int k = 0; k < MAX_RES; k++) begin
        list_r[k] <= list_nxt[k];
      end
    end
  end

`ifndef ASSERT_OFF
  // the read pointer never runs past the loaded list
  a_idx_in_list: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> ({1'b0, out_idx_r} < out_cnt_r))
    else $error("result index beyond list length");

  // a finished list restarts at its first entry
  a_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (take && out_ch.last) |=> (out_idx_r == '0))
    else $error("result index not rewound after last transaction");

  // fire is always followed by its beeps within the same sample
  a_fire_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.action == ACT_FIRE) |-> !out_ch.last)
    else $error("fire result marked last");

  // a stalled input side means a sample waits in the input register
  a_stall_held: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> (in_vld_r && out_ch.valid))
    else $error("input stalled without pending work");
`endif

endmodule

// File: verif/afap_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the arm / fire / abort panel sequencer: watches sample, result and register
// channels, predicts the command stream and compares it. Depends on afap_pkg and the afap_*_if.
module afap_checker (
  input  logic clk,
  input  logic rst_n,
  afap_in_if   in_mon,
  afap_out_if  out_mon,
  afap_cfg_if  cfg_mon,
  output int   fails,
  output int   pending,
  output int   checked
);
  import afap_pkg::*;

  typedef struct packed {
    logic [2:0]  action;
    logic [10:0] tone_hz;
    logic [15:0] tone_ms;
    logic        last;
  } panel_cmd_t;

  panel_cmd_t cmds_due[$];

  // register copies
  logic [15:0] abort_repeat;
  logic [19:0] auto_disarm;
  logic [15:0] beep_interval;
  logic [15:0] beep_length;

  // panel state
  logic              arm_prev, fire_prev, abort_prev, armed;
  logic [TIME_W-1:0] armed_since, last_beep, last_abort;

  int fail_cnt    = 0;
  int checked_cnt = 0;

  function automatic panel_cmd_t mk_cmd(input logic [2:0] act, input logic [10:0] hz,
                                        input logic [15:0] ms);
    panel_cmd_t c;
    c = '{action: act, tone_hz: hz, tone_ms: ms, last: 1'b0};
    return c;
  endfunction

  task automatic predict_panel(input logic arm, input logic fire, input logic abt,
                               input logic [TIME_W-1:0] now);
    panel_cmd_t        burst[$];
    logic [TIME_W-1:0] span;
    if (arm && !arm_prev && abt) begin
      burst.push_back(mk_cmd(ACT_ARM, '0, '0));
      burst.push_back(mk_cmd(ACT_BEEP, ARM_TONE_HZ, ARM_TONE_MS));
      armed       = 1'b1;
      armed_since = now;
      last_beep   = now;
    end else if (!arm && arm_prev) begin
      burst.push_back(mk_cmd(ACT_STOP, '0, '0));
      burst.push_back(mk_cmd(ACT_SILENCE, '0, '0));
      armed = 1'b0;
    end

    if (fire && !fire_prev && armed) begin
      burst.push_back(mk_cmd(ACT_FIRE, '0, '0));
      repeat (FIRE_BEEPS) burst.push_back(mk_cmd(ACT_BEEP, FIRE_TONE_HZ, FIRE_TONE_MS));
    end

    // abort is active low; release gives one stop
    if (!abt) begin
      span = now - last_abort;
      if (span >= abort_repeat) begin
        burst.push_back(mk_cmd(ACT_ABORT, '0, '0));
        last_abort = now;
      end
    end else if (!abort_prev) begin
      burst.push_back(mk_cmd(ACT_STOP, '0, '0));
    end

    // timestamps wrap at 32 bits, so differences are taken at that width
    if (armed) begin
      span = now - armed_since;
      if (span >= auto_disarm) begin
        burst.push_back(mk_cmd(ACT_STOP, '0, '0));
        armed = 1'b0;
      end else begin
        span = now - last_beep;
        if (span >= beep_interval) begin
          burst.push_back(mk_cmd(ACT_BEEP, REM_TONE_HZ, beep_length));
          last_beep = now;
        end
      end
    end

    arm_prev   = arm;
    fire_prev  = fire;
    abort_prev = abt;

    if (burst.size() > 0) burst[burst.size()-1].last = 1'b1;
    foreach (burst[k]) cmds_due.push_back(burst[k]);
  endtask

  task automatic report_field(input string name, input logic [15:0] want,
                              input logic [15:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      fail_cnt++;
    end
  endtask

  always @(posedge clk) begin : watch_edge
    panel_cmd_t got;
    panel_cmd_t want;
    if (!rst_n) begin
      abort_repeat  = ABORT_REPEAT_RST;
      auto_disarm   = AUTO_DISARM_RST;
      beep_interval = BEEP_INTERVAL_RST;
      beep_length   = BEEP_LENGTH_RST;
      arm_prev      = 1'b0;
      fire_prev     = 1'b0;
      abort_prev    = 1'b1;
      armed         = 1'b0;
      armed_since   = '0;
      last_beep     = '0;
      last_abort    = '0;
      cmds_due.delete();
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        got = '{action: out_mon.action, tone_hz: out_mon.tone_hz,
                tone_ms: out_mon.tone_ms, last: out_mon.last};
        if (cmds_due.size() == 0) begin
          $display("%0t: result with nothing expected, got action %0d tone %0d Hz %0d ms last %0b",
                   $time, got.action, got.tone_hz, got.tone_ms, got.last);
          fail_cnt++;
        end else begin
          want = cmds_due.pop_front();
          checked_cnt++;
          report_field("action", 16'(want.action), 16'(got.action));
          report_field("tone_hz", 16'(want.tone_hz), 16'(got.tone_hz));
          report_field("tone_ms", want.tone_ms, got.tone_ms);
          report_field("last", 16'(want.last), 16'(got.last));
        end
      end

      if (cfg_mon.valid && cfg_mon.ready) begin
        case (cfg_mon.index)
          REG_ABORT_REPEAT:  abort_repeat  = cfg_mon.data[15:0];
          REG_AUTO_DISARM:   auto_disarm   = cfg_mon.data[19:0];
          REG_BEEP_INTERVAL: beep_interval = cfg_mon.data[15:0];
          REG_BEEP_LENGTH:   beep_length   = cfg_mon.data[15:0];
          default: ;
        endcase
      end

      if (in_mon.valid && in_mon.ready)
        predict_panel(in_mon.arm_level, in_mon.fire_level, in_mon.abort_level, in_mon.now_ms);
    end

    fails   <= fail_cnt;
    pending <= cmds_due.size();
    checked <= checked_cnt;
  end

endmodule

// File: verif/tb.sv
`timescale 1ns / 1ps
// Top of the panel sequencer testbench: clock, reset, sample and register stimulus, result
// back-pressure and verdict. Depends on afap_pkg, the afap_*_if, the block and afap_checker.
module tb;
  import afap_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_CYCLES    = 150;
  localparam int DRAIN_CYCLES   = 6;
  localparam int PHASE_ITEMS    = 70;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  int   send_idle_pct = 0;
  int   recv_idle_pct = 0;
  logic hold_go       = 1'b0;
  int   quiet         = 0;
  int   samples_sent  = 0;
  int   reg_writes    = 0;
  int   fails, pending, checked;

  // last levels and time sent, so random samples continue from there
  logic              cur_arm, cur_fire, cur_abt;
  logic [TIME_W-1:0] t_now;

  afap_in_if  in_ch ();
  afap_out_if out_ch ();
  afap_cfg_if cfg_ch ();

  arm_fire_abort_panel_sequencer u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  afap_checker u_chk (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_mon  (in_ch),
    .out_mon (out_ch),
    .cfg_mon (cfg_ch),
    .fails   (fails),
    .pending (pending),
    .checked (checked)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic send_sample(input logic a, input logic f, input logic b,
                             input logic [TIME_W-1:0] t);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.arm_level   <= a;
    in_ch.fire_level  <= f;
    in_ch.abort_level <= b;
    in_ch.now_ms      <= t;
    cur_arm  = a;
    cur_fire = f;
    cur_abt  = b;
    t_now    = t;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    samples_sent++;
  endtask

  // valid stays high across back-to-back writes; caller lowers it
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    reg_writes++;
  endtask

  // upper data bits are junk the block must drop; an unmapped index goes last
  task automatic set_regs(input logic [15:0] abort_rep, input logic [19:0] disarm,
                          input logic [15:0] interval, input logic [15:0] length);
    write_reg(REG_ABORT_REPEAT, {16'($urandom), abort_rep});
    write_reg(REG_AUTO_DISARM, {12'($urandom), disarm});
    write_reg(REG_BEEP_INTERVAL, {16'($urandom), interval});
    write_reg(REG_BEEP_LENGTH, {16'($urandom), length});
    write_reg(CFG_IDX_W'(REG_BEEP_LENGTH + 1 + $urandom_range(251)), $urandom);
    cfg_ch.valid <= 1'b0;
  endtask

  // a sample may cause no result, so wait out the pipeline after the queue empties
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic random_samples(input int count);
    int                roll;
    logic              a, f, b;
    repeat (count) begin
      a = cur_arm;
      f = cur_fire;
      b = cur_abt;
      if ($urandom_range(99) < 10) begin
        {a, f, b} = 3'($urandom_range(7));
      end else begin
        if ($urandom_range(99) < 25) a = !a;
        if ($urandom_range(99) < 30) f = !f;
        if ($urandom_range(99) < (b ? 12 : 40)) b = !b;
      end
      roll = $urandom_range(99);
      if (roll < 3)
        send_sample(a, f, b, $urandom);
      else if (roll < 10)
        send_sample(a, f, b, t_now + $urandom_range(1000, 1100000));
      else if (roll < 35)
        send_sample(a, f, b, t_now + $urandom_range(600, 3000));
      else
        send_sample(a, f, b, t_now + $urandom_range(0, 600));
    end
  endtask

  // result side back-pressure, with one long hold-off on request
  initial begin : result_sink
    int hold_cnt;
    hold_cnt = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_go && hold_cnt < HOLD_CYCLES) begin
        out_ch.ready <= 1'b0;
        hold_cnt++;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready))
      quiet <= 0;
    else
      quiet <= quiet + 1;
    if (quiet >= WATCHDOG_LIMIT) begin
      $display("%0t: no transaction for %0d cycles, %0d results outstanding",
               $time, quiet, pending);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    in_ch.valid       <= 1'b0;
    in_ch.arm_level   <= 1'b0;
    in_ch.fire_level  <= 1'b0;
    in_ch.abort_level <= 1'b1;
    in_ch.now_ms      <= '0;
    cfg_ch.valid      <= 1'b0;
    cfg_ch.index      <= '0;
    cfg_ch.data       <= '0;
    cur_arm  = 1'b0;
    cur_fire = 1'b0;
    cur_abt  = 1'b1;
    t_now    = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle_pct = 13;
    recv_idle_pct <= 57;

    // reset register values
    send_sample(1'b0, 1'b0, 1'b1, 32'd0);
    send_sample(1'b0, 1'b1, 1'b1, 32'd100);          // fire while disarmed
    send_sample(1'b0, 1'b0, 1'b1, 32'd200);
    send_sample(1'b1, 1'b0, 1'b1, 32'd300);          // arm
    send_sample(1'b1, 1'b1, 1'b1, 32'd400);          // fire burst
    send_sample(1'b1, 1'b0, 1'b1, 32'd1400);         // reminder beep
    send_sample(1'b1, 1'b0, 1'b0, 32'd1500);         // abort
    send_sample(1'b1, 1'b0, 1'b0, 32'd1700);
    send_sample(1'b1, 1'b0, 1'b0, 32'd2000);         // repeat exactly at the interval
    send_sample(1'b1, 1'b0, 1'b1, 32'd2100);         // abort release
    send_sample(1'b0, 1'b0, 1'b1, 32'd2200);         // disarm
    send_sample(1'b1, 1'b0, 1'b0, 32'd2300);         // arm blocked by abort
    send_sample(1'b1, 1'b0, 1'b1, 32'd2400);
    send_sample(1'b0, 1'b0, 1'b1, 32'd2500);         // falling arm, never armed
    send_sample(1'b1, 1'b0, 1'b1, 32'hFFFF_FE00);
    send_sample(1'b1, 1'b0, 1'b1, 32'h0000_0300);    // beep across the time wrap
    send_sample(1'b1, 1'b0, 1'b1, 32'h0000_7600);    // auto-disarm across the wrap
    send_sample(1'b1, 1'b1, 1'b1, 32'h0000_7700);
    send_sample(1'b0, 1'b0, 1'b1, 32'hFFFF_FFFF);
    drain();

    // minimum intervals, zero reminder interval, longest beep
    set_regs(16'd1, 20'd1, 16'd0, 16'hFFFF);
    send_sample(1'b0, 1'b0, 1'b0, 32'hFFFF_FFFF);
    send_sample(1'b1, 1'b1, 1'b1, 32'hFFFF_FFFF);    // full eight-result burst
    send_sample(1'b1, 1'b1, 1'b1, 32'hFFFF_FFFF);
    send_sample(1'b1, 1'b0, 1'b1, 32'd0);
    drain();

    // zero abort and disarm intervals fire on every sample while abort is held or the panel is armed
    set_regs(16'd0, 20'd0, 16'hFFFF, 16'd0);
    send_sample(1'b0, 1'b0, 1'b0, 32'h5555_AAAA);
    send_sample(1'b1, 1'b1, 1'b1, 32'hAAAA_5555);    // arm, fire, release and auto stop
    drain();

    set_regs(16'($urandom_range(1, 1500)), 20'($urandom_range(2000, 20000)),
             16'($urandom_range(1, 1500)), 16'($urandom_range(0, 65535)));
    random_samples(PHASE_ITEMS);
    drain();

    send_idle_pct = 57;
    recv_idle_pct <= 13;
    set_regs(16'hFFFF, 20'd1000000, 16'd1, 16'd0);
    random_samples(PHASE_ITEMS);
    drain();

    send_idle_pct = 0;
    recv_idle_pct <= 0;
    set_regs(16'($urandom_range(1, 800)), 20'($urandom_range(1, 8000)),
             16'($urandom_range(1, 800)), 16'($urandom_range(0, 65535)));
    random_samples(20);
    hold_go <= 1'b1;                                 // result side stalls, input backs up
    random_samples(PHASE_ITEMS - 20);
    drain();

    $display("Ran %0d samples and %0d register writes under three stall mixes and one long hold",
             samples_sent, reg_writes);
    $display("Compared %0d results, %0d mismatches", checked, fails);
    if (fails == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
